[hw/rtl/pixel_hit_map_accumulator_top_assert.svh]
// Assertion macros used by phm_ctrl.
`ifndef PIXEL_HIT_MAP_ACCUMULATOR_TOP_ASSERT_SVH
`define PIXEL_HIT_MAP_ACCUMULATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PHM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PHM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PHM_ASSERT(lbl, prop, msg)
`define PHM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hw/rtl/phm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package phm_pkg;

	localparam logic [1:0] REQ_HEADER = 2'd0;
	localparam logic [1:0] REQ_HIT    = 2'd1;
	localparam logic [1:0] REQ_EOE    = 2'd2;
	localparam logic [1:0] REQ_READ   = 2'd3;

	localparam logic KIND_EOE  = 1'b0;
	localparam logic KIND_CELL = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] chip_count;
		logic [2:0] chip_index;
		logic [7:0] hit_col;
		logic [7:0] hit_row;
	} phm_req_t;

	typedef struct packed {
		logic        result_kind;
		logic        event_error;
		logic [31:0] cell_count;
		logic [31:0] wrong_count_events;
		logic [31:0] bad_address_hits;
	} phm_rsp_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INC,
		ST_RD
	} phm_state_t;

endpackage

`default_nettype wire

[hw/rtl/pixel_hit_map_accumulator_top.sv]
// Pixel hit map accumulator.
// Request channel (req_valid / req_stall / req) carries headers, hits, end of
// event markers and map reads; a beat is taken when req_valid is high and
// req_stall is low. Response channel (rsp_valid / rsp_stall / rsp) returns an
// end-of-event status or a map cell answer with both error counters.
// Header, end of event and an ignored or bad-address hit finish in ST_IDLE;
// a counted hit also passes through ST_INC and a read through ST_RD, set by
// the registered read of the map memory and, for a hit, the write back.
// An end-of-event status appears the cycle after its beat; a read answer is
// loaded from the memory read data in ST_RD. Only one request is in work at
// a time, so a hit's read-modify-write never overlaps another access.
// The response sits in an output register; while rsp is stalled the block
// still finishes the item in work but takes no new request.
// After reset the map memory is swept to zero, one cell a cycle, through all
// CHIPS*COLUMNS*ROWS cells (33280 by default); req_stall is high meanwhile.
// Counters and the event state reset at once.
`timescale 1ns / 1ps
`default_nettype none

module pixel_hit_map_accumulator_top
	import phm_pkg::*;
#(
	parameter int CHIPS   = 8,
	parameter int COLUMNS = 52,
	parameter int ROWS    = 80
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire phm_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output phm_rsp_t      rsp
);

	localparam int DEPTH = CHIPS * COLUMNS * ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;

	phm_ctrl #(
		.CHIPS   (CHIPS),
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.DEPTH   (DEPTH),
		.AW      (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	phm_map_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

[hw/rtl/phm_map_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module phm_map_ram #(
	parameter int DEPTH = 33280,
	parameter int AW    = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/phm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_hit_map_accumulator_top_assert.svh"

module phm_ctrl
	import phm_pkg::*;
#(
	parameter int CHIPS   = 8,
	parameter int COLUMNS = 52,
	parameter int ROWS    = 80,
	parameter int DEPTH   = 33280,
	parameter int AW      = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire phm_req_t      req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output phm_rsp_t           rsp,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [31:0]        mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	input  wire logic [31:0]   mem_rdata
);

	localparam int PLANE = COLUMNS * ROWS;

	phm_state_t  state_q, state_d;
	logic [AW-1:0] clr_q;
	logic        acc_q;
	logic        flag_q;
	logic [31:0] wcc_q;
	logic [31:0] bac_q;
	logic        rsp_valid_q;
	phm_rsp_t    rsp_q;
	logic [AW-1:0] addr_q;
	logic        rng_q;

	logic        accept;
	logic        in_range;
	logic        count_ok;
	logic [31:0] addr_w;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign in_range = ({29'd0, req.chip_index} < 32'(CHIPS))
		&& ({24'd0, req.hit_col} < 32'(COLUMNS))
		&& ({24'd0, req.hit_row} < 32'(ROWS));
	assign count_ok = ({28'd0, req.chip_count} == 32'(CHIPS));
	assign addr_w   = {29'd0, req.chip_index} * 32'(PLANE)
		+ {24'd0, req.hit_col} * 32'(ROWS) + {24'd0, req.hit_row};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && req.req_type == REQ_HIT && acc_q && in_range) begin
					state_d = ST_INC;
				end else if (accept && req.req_type == REQ_READ) begin
					state_d = ST_RD;
				end
			end
			ST_INC: state_d = ST_IDLE;
			ST_RD:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = mem_rdata + 32'd1;
		mem_re    = 1'b0;
		mem_raddr = addr_w[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 32'd0;
			end
			ST_IDLE: mem_re = accept;
			ST_INC:  mem_we = 1'b1;
			ST_RD:   mem_re = 1'b0;
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			acc_q       <= 1'b0;
			flag_q      <= 1'b0;
			wcc_q       <= 32'd0;
			bac_q       <= 32'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_RD || (accept && req.req_type == REQ_EOE)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept) begin
				unique case (req.req_type)
					REQ_HEADER: begin
						acc_q  <= count_ok;
						flag_q <= !count_ok;
						if (!count_ok) begin
							wcc_q <= wcc_q + 32'd1;
						end
					end
					REQ_HIT: begin
						if (acc_q && !in_range) begin
							bac_q  <= bac_q + 32'd1;
							flag_q <= 1'b1;
						end
					end
					REQ_EOE: begin
						acc_q  <= 1'b0;
						flag_q <= 1'b0;
					end
					REQ_READ: begin
						acc_q <= acc_q;
					end
					default: acc_q <= acc_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= addr_w[AW-1:0];
			rng_q  <= in_range;
		end
		if (accept && req.req_type == REQ_EOE) begin
			rsp_q <= '{KIND_EOE, flag_q, 32'd0, wcc_q, bac_q};
		end else if (state_q == ST_RD) begin
			rsp_q <= '{KIND_CELL, 1'b0, (rng_q ? mem_rdata : 32'd0), wcc_q, bac_q};
		end
	end

	`PHM_ASSERT(a_clear_no_rsp, state_q == ST_CLEAR |-> !rsp_valid_q, "beat during clear")
	`PHM_ASSERT(a_inc_after_read, state_q == ST_INC |-> $past(mem_re), "increment without read")
	`PHM_ASSERT(a_rd_loads_rsp, state_q == ST_RD |=> rsp_valid_q, "read answer lost")
	`PHM_ASSERT_ALWAYS(a_clr_bound, state_q == ST_CLEAR |-> clr_q <= AW'(DEPTH - 1), "clear overrun")

endmodule

`default_nettype wire
